/* rtl/indexed_priority_task_table_macros.svh */
// Assertion helpers for the task table.
`ifndef INDEXED_PRIORITY_TASK_TABLE_MACROS_SVH
`define INDEXED_PRIORITY_TASK_TABLE_MACROS_SVH

// Checks that the consequent follows at the same edge.
`define IPTT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("task table check failed");

// Checks that the consequent holds at the next edge.
`define IPTT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("task table check failed");

`endif

/* rtl/iptt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task table package
// Codes, field widths and shared types of the task table.
// ----------------------------------------------------------------------------
package iptt_pkg;

	localparam int DefaultCapacity = 64;
	localparam int KeyW = 20;
	localparam int OwnerW = 20;
	localparam int PrioW = 30;
	localparam int CmdW = 2;
	localparam int StatusW = 3;
	localparam int InDataW = 72;
	localparam int OutDataW = 24;

	localparam logic [CmdW-1:0] CMD_ADD = 2'd0;
	localparam logic [CmdW-1:0] CMD_CHANGE = 2'd1;
	localparam logic [CmdW-1:0] CMD_REMOVE = 2'd2;
	localparam logic [CmdW-1:0] CMD_TAKE = 2'd3;

	localparam logic [StatusW-1:0] ST_OK = 3'd0;
	localparam logic [StatusW-1:0] ST_EMPTY = 3'd1;
	localparam logic [StatusW-1:0] ST_FULL = 3'd2;
	localparam logic [StatusW-1:0] ST_UNKNOWN = 3'd3;
	localparam logic [StatusW-1:0] ST_DUP = 3'd4;

	typedef struct packed {
		logic valid;
		logic [KeyW-1:0] task_key;
		logic [OwnerW-1:0] owner;
		logic [PrioW-1:0] prio;
	} entry_t;

	typedef struct packed {
		logic accept;
		logic rd_en;
		logic proc_en;
		logic clear_we;
		logic commit;
	} dp_cmd_t;

endpackage

/* rtl/iptt_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task table datapath
// Slot memory, scan trackers, result logic and the output data register.
// ----------------------------------------------------------------------------
module iptt_datapath import iptt_pkg::*; #(
	parameter int CAPACITY = DefaultCapacity,
	parameter int AW = $clog2(CAPACITY)
) (
	input  logic clk,
	input  logic arst_n,
	input  dp_cmd_t cmd,
	input  logic [AW-1:0] addr,
	input  logic [CmdW-1:0] in_cmd,
	input  logic [KeyW-1:0] in_key,
	input  logic [OwnerW-1:0] in_owner,
	input  logic [PrioW-1:0] in_prio,
	output logic [OwnerW-1:0] owner_out,
	output logic [StatusW-1:0] status
);

	entry_t mem [CAPACITY];
	entry_t rdata_s1;
	logic [AW-1:0] ridx_s1;

	logic [CmdW-1:0] cmd_q;
	logic [KeyW-1:0] key_q;
	logic [OwnerW-1:0] owner_q;
	logic [PrioW-1:0] prio_q;

	logic match_vld_q, free_vld_q, best_vld_q;
	logic [AW-1:0] match_idx_q, free_idx_q, best_idx_q;
	logic [OwnerW-1:0] match_owner_q, best_owner_q;
	logic [KeyW-1:0] best_key_q;
	logic [PrioW-1:0] best_prio_q;

	logic we;
	logic [AW-1:0] waddr;
	entry_t wdata;
	logic [StatusW-1:0] res_status;
	logic [OwnerW-1:0] res_owner;
	logic better;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem[addr];
			ridx_s1 <= addr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q <= in_cmd;
			key_q <= in_key;
			owner_q <= in_owner;
			prio_q <= in_prio;
		end
	end

	assign better = rdata_s1.valid && (!best_vld_q || rdata_s1.prio > best_prio_q ||
		(rdata_s1.prio == best_prio_q && rdata_s1.task_key > best_key_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_vld_q <= 1'b0;
			free_vld_q <= 1'b0;
			best_vld_q <= 1'b0;
		end else if (cmd.accept) begin
			match_vld_q <= 1'b0;
			free_vld_q <= 1'b0;
			best_vld_q <= 1'b0;
		end else if (cmd.proc_en) begin
			if (rdata_s1.valid && rdata_s1.task_key == key_q && !match_vld_q) begin
				match_vld_q <= 1'b1;
			end
			if (!rdata_s1.valid && !free_vld_q) begin
				free_vld_q <= 1'b1;
			end
			if (better) begin
				best_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.proc_en) begin
			if (rdata_s1.valid && rdata_s1.task_key == key_q && !match_vld_q) begin
				match_idx_q <= ridx_s1;
				match_owner_q <= rdata_s1.owner;
			end
			if (!rdata_s1.valid && !free_vld_q) begin
				free_idx_q <= ridx_s1;
			end
			if (better) begin
				best_idx_q <= ridx_s1;
				best_owner_q <= rdata_s1.owner;
				best_key_q <= rdata_s1.task_key;
				best_prio_q <= rdata_s1.prio;
			end
		end
	end

	always_comb begin
		we = 1'b0;
		waddr = addr;
		wdata = '0;
		res_status = ST_OK;
		res_owner = '0;
		unique case (cmd_q)
			CMD_ADD: begin
				if (match_vld_q) begin
					res_status = ST_DUP;
				end else if (!free_vld_q) begin
					res_status = ST_FULL;
				end else begin
					we = cmd.commit;
					waddr = free_idx_q;
					wdata = '{valid: 1'b1, task_key: key_q, owner: owner_q, prio: prio_q};
				end
			end
			CMD_CHANGE: begin
				if (!match_vld_q) begin
					res_status = ST_UNKNOWN;
				end else begin
					we = cmd.commit;
					waddr = match_idx_q;
					wdata = '{valid: 1'b1, task_key: key_q, owner: match_owner_q,
						prio: prio_q};
				end
			end
			CMD_REMOVE: begin
				if (!match_vld_q) begin
					res_status = ST_UNKNOWN;
				end else begin
					we = cmd.commit;
					waddr = match_idx_q;
				end
			end
			default: begin
				if (!best_vld_q) begin
					res_status = ST_EMPTY;
				end else begin
					res_owner = best_owner_q;
					we = cmd.commit;
					waddr = best_idx_q;
				end
			end
		endcase
		if (cmd.clear_we) begin
			we = 1'b1;
			waddr = addr;
			wdata = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			owner_out <= res_owner;
			status <= res_status;
		end
	end

endmodule

/* rtl/iptt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task table controller
// Sequences the clearing pass, the slot scan, the commit and the output.
// ----------------------------------------------------------------------------
module iptt_ctrl import iptt_pkg::*; #(
	parameter int CAPACITY = DefaultCapacity,
	parameter int AW = $clog2(CAPACITY),
	parameter int CW = $clog2(CAPACITY + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output dp_cmd_t cmd,
	output logic [AW-1:0] addr
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;
	localparam logic [CW-1:0] Last = CW'(CAPACITY - 1);
	localparam logic [CW-1:0] Cap = CW'(CAPACITY);

	logic [2:0] state_q;
	logic [CW-1:0] cnt_q;
	logic rd_vld_s1;
	logic out_free;

	assign addr = cnt_q[AW-1:0];
	assign in_ready = state_q == S_IDLE;
	assign out_free = !out_valid || out_ready;

	always_comb begin
		cmd.accept = in_valid && in_ready;
		cmd.rd_en = state_q == S_SCAN && cnt_q != Cap;
		cmd.proc_en = rd_vld_s1;
		cmd.clear_we = state_q == S_CLEAR;
		cmd.commit = state_q == S_DONE && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q <= '0;
			rd_vld_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == Last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					cnt_q <= '0;
					if (cmd.accept) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (cnt_q == Cap) begin
						state_q <= S_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/indexed_priority_task_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed priority task table
// Table of tasks with add, change, remove and take-top commands.
// ----------------------------------------------------------------------------
// Commands enter on the s_ channel: s_tuser is the command code, s_tdata holds
// task key, owner and priority. Each transaction gives exactly one result on
// the m_ channel: m_tdata is the owner of a taken task, m_tuser the status.
// Every command scans all slots of the slot memory through its single read
// port, one slot per cycle; a new command is taken only once the result of
// the last one is in the output register. After reset the block clears the
// slot memory, one slot a cycle, with s_tready low. A result waits in the
// output register while the receiver stalls; the next command is accepted
// and scanned meanwhile, and finishes once the register is free.
// The top task is the highest priority, ties going to the highest key.
// ----------------------------------------------------------------------------
`include "indexed_priority_task_table_macros.svh"

module indexed_priority_task_table import iptt_pkg::*; #(
	parameter int CAPACITY = DefaultCapacity
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [InDataW-1:0] s_tdata,  // task_key, owner, prio, zero pad
	input  logic [CmdW-1:0] s_tuser,     // cmd
	output logic m_tvalid,
	input  logic m_tready,
	output logic [OutDataW-1:0] m_tdata, // owner_out, zero pad
	output logic [StatusW-1:0] m_tuser   // status
);

	localparam int AW = $clog2(CAPACITY);

	dp_cmd_t cmd;
	logic [AW-1:0] addr;
	logic [OwnerW-1:0] owner_out;

	iptt_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.cmd(cmd),
		.addr(addr)
	);

	iptt_datapath #(.CAPACITY(CAPACITY)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.addr(addr),
		.in_cmd(s_tuser),
		.in_key(s_tdata[KeyW-1:0]),
		.in_owner(s_tdata[KeyW+OwnerW-1:KeyW]),
		.in_prio(s_tdata[KeyW+OwnerW+PrioW-1:KeyW+OwnerW]),
		.owner_out(owner_out),
		.status(m_tuser)
	);

	assign m_tdata = {{(OutDataW-OwnerW){1'b0}}, owner_out};

	`IPTT_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
	`IPTT_ASSERT_NOW(a_status_range, m_tvalid, m_tuser <= ST_DUP)
	`IPTT_ASSERT_NOW(a_owner_only_ok, m_tvalid && m_tuser != ST_OK, m_tdata == '0)
	`IPTT_ASSERT_NOW(a_no_commit_when_blocked, m_tvalid && !m_tready, !cmd.commit)

endmodule
